[rtl/core/ppg_pkg.sv]
`timescale 1ns / 1ps

package ppg_pkg;

  // Peak ring geometry
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0]  RING_FULL = FILL_W'(RING_DEPTH);

  // Sample and fixed-point widths
  localparam int SAMPLE_W  = 18;
  localparam int TIME_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int BASE_W    = SAMPLE_W + FRAC_BITS;
  localparam int COUNT_W   = 5;

  // APB register map
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam logic [2:0] REG_EMA_SHIFT  = 3'd0;
  localparam logic [2:0] REG_PEAK_OFF   = 3'd1;
  localparam logic [2:0] REG_HYSTERESIS = 3'd2;
  localparam logic [2:0] REG_REFRACTORY = 3'd3;
  localparam logic [2:0] REG_WINDOW     = 3'd4;

  // Register reset values
  localparam logic [3:0]  EMA_SHIFT_RST  = 4'd4;
  localparam logic [17:0] PEAK_OFF_RST   = 18'd2000;
  localparam logic [17:0] HYSTERESIS_RST = 18'd500;
  localparam logic [15:0] REFRACTORY_RST = 16'd300;
  localparam logic [19:0] WINDOW_RST     = 20'd10000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ir_sample;
    logic [TIME_W-1:0]   stamp_ms;
  } in_t;

  typedef struct packed {
    logic                peak_found;
    logic [TIME_W-1:0]   found_time_ms;
    logic [COUNT_W-1:0]  recent_count;
    logic [TIME_W-1:0]   recent_span_ms;
  } out_t;

  typedef struct packed {
    logic [3:0]  ema_shift;
    logic [17:0] entry_margin;
    logic [17:0] hysteresis;
    logic [15:0] min_gap_ms;
    logic [19:0] window_ms;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic do_base;
    logic do_peak;
    logic do_conf;
    logic do_chk;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_end;
    logic age_over;
  } sts_t;

endpackage

[rtl/core/ppg_pulse_peak_detector.sv]
`timescale 1ns / 1ps

// Pulse peak detector for optical pulse samples.
// Input channel in_valid/in_stall/in_data carries one sample and its
// millisecond timestamp per transaction; output channel out_valid/out_stall/
// out_data returns exactly one result per sample: peak flag and time, count
// of newest ring peaks inside the window, and their time span.
// One sample is processed at a time. The steps are capture on accept,
// baseline, region test and confirm, then for each ring entry tested a
// registered ring read followed by an age test, one more read when the walk
// runs past the stored entries, and a load of the output register. A new
// sample is taken only once the previous result has been loaded, and the
// ring holds 16 entries.
// in_stall is high while a sample is being worked on. The output register
// lets the next sample be accepted while a result still waits; a stalled
// result holds and the following one waits in the final state until taken.
// Reset (rst_n, synchronous) loads the register defaults, empties the ring
// and clears the baseline; no clearing pass is needed.
// APB registers at byte addresses 0x00 ema_shift, 0x04 entry_margin,
// 0x08 hysteresis, 0x0C min_gap_ms, 0x10 window_ms; write only when idle.

module ppg_pulse_peak_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ppg_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ppg_pkg::out_t                 out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppg_pkg::APB_AW-1:0]    paddr,
  input  logic [ppg_pkg::APB_DW-1:0]    pwdata,
  output logic [ppg_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  ppg_pkg::cfg_t cfg_r;
  ppg_pkg::cmd_t cmd;
  ppg_pkg::sts_t sts;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_shift    <= ppg_pkg::EMA_SHIFT_RST;
      cfg_r.entry_margin <= ppg_pkg::PEAK_OFF_RST;
      cfg_r.hysteresis   <= ppg_pkg::HYSTERESIS_RST;
      cfg_r.min_gap_ms   <= ppg_pkg::REFRACTORY_RST;
      cfg_r.window_ms    <= ppg_pkg::WINDOW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ppg_pkg::REG_EMA_SHIFT:  cfg_r.ema_shift    <= pwdata[3:0];
        ppg_pkg::REG_PEAK_OFF:   cfg_r.entry_margin <= pwdata[17:0];
        ppg_pkg::REG_HYSTERESIS: cfg_r.hysteresis   <= pwdata[17:0];
        ppg_pkg::REG_REFRACTORY: cfg_r.min_gap_ms   <= pwdata[15:0];
        ppg_pkg::REG_WINDOW:     cfg_r.window_ms    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      ppg_pkg::REG_EMA_SHIFT:  prdata = {28'b0, cfg_r.ema_shift};
      ppg_pkg::REG_PEAK_OFF:   prdata = {14'b0, cfg_r.entry_margin};
      ppg_pkg::REG_HYSTERESIS: prdata = {14'b0, cfg_r.hysteresis};
      ppg_pkg::REG_REFRACTORY: prdata = {16'b0, cfg_r.min_gap_ms};
      ppg_pkg::REG_WINDOW:     prdata = {12'b0, cfg_r.window_ms};
      default:                 prdata = '0;
    endcase
  end

  ppg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ppg_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_data (out_data)
  );

endmodule

[rtl/core/ppg_ram.sv]
`timescale 1ns / 1ps

module ppg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ppg_ctrl.sv]
`timescale 1ns / 1ps

module ppg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output ppg_pkg::cmd_t cmd,
  input  ppg_pkg::sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_BASE = 7'b0000010,
    S_PEAK = 7'b0000100,
    S_CONF = 7'b0001000,
    S_RD   = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_BASE;
        end
      end
      S_BASE: begin
        cmd.do_base = 1'b1;
        state_nxt   = S_PEAK;
      end
      S_PEAK: begin
        cmd.do_peak = 1'b1;
        state_nxt   = S_CONF;
      end
      S_CONF: begin
        cmd.do_conf = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        // read of the next ring entry is in flight
        state_nxt = sts.walk_end ? S_DONE : S_CHK;
      end
      S_CHK: begin
        cmd.do_chk = !sts.age_over;
        state_nxt  = sts.age_over ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Each entry check follows its read
  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> $past(state_r) == S_RD)
    else $error("entry check without a preceding read");

  // A result is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && out_valid_r |-> !out_stall)
    else $error("pending result overwritten");

  // An accepted item always moves the controller into the baseline step
  a_accept_to_base: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_BASE)
    else $error("accepted item did not start processing");

endmodule

[rtl/core/ppg_dp.sv]
`timescale 1ns / 1ps

module ppg_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  ppg_pkg::cmd_t cmd,
  output ppg_pkg::sts_t sts,
  input  ppg_pkg::in_t  in_data,
  input  ppg_pkg::cfg_t cfg,
  output ppg_pkg::out_t out_data
);

  localparam int SW = ppg_pkg::SAMPLE_W;
  localparam int TW = ppg_pkg::TIME_W;
  localparam int BW = ppg_pkg::BASE_W;
  localparam int AW = ppg_pkg::RING_AW;
  localparam int FW = ppg_pkg::FILL_W;
  localparam int FB = ppg_pkg::FRAC_BITS;

  // Captured item
  logic [SW-1:0] x_r;
  logic [TW-1:0] now_r;

  // Detector state
  logic [BW-1:0] base_r, base_nxt;
  logic          primed_r;
  logic          inside_r;
  logic [SW-1:0] rmax_r;
  logic [TW-1:0] rmt_r;
  logic [TW-1:0] lct_r;
  logic          have_r;
  logic          exit_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r;

  // Per-item results and window walk
  logic          found_r;
  logic [TW-1:0] ftime_r;
  logic [AW-1:0] wp_r;
  logic [FW-1:0] cnt_r;
  logic [TW-1:0] newest_r;
  logic [TW-1:0] oldest_r;
  ppg_pkg::out_t out_r;

  logic [BW-1:0] xf;
  logic [BW-1:0] diff;
  logic [BW:0]   entry_lvl;
  logic [BW:0]   xf_ext;
  logic [BW:0]   exit_lvl;
  logic          enter_hit;
  logic          exit_hit;
  logic [TW-1:0] gap;
  logic          confirm;
  logic          push;
  logic [TW-1:0] ring_rdata;
  logic [TW-1:0] age;

  assign xf = {x_r, FB'(0)};

  // Baseline step: exponential average by shift, first sample primes it
  always_comb begin
    if (xf >= base_r) begin
      diff     = (xf - base_r) >> cfg.ema_shift;
      base_nxt = base_r + diff;
    end else begin
      diff     = (base_r - xf) >> cfg.ema_shift;
      base_nxt = base_r - diff;
    end
  end

  // Entry and exit levels, exact at one extra bit
  assign entry_lvl = {1'b0, base_r} + {1'b0, cfg.entry_margin, FB'(0)};
  assign xf_ext    = {1'b0, xf};
  assign exit_lvl  = xf_ext + {1'b0, cfg.hysteresis, FB'(0)};
  assign enter_hit = !inside_r && (xf_ext > entry_lvl);
  assign exit_hit  = inside_r && (exit_lvl < entry_lvl);

  // Refractory test on region close
  assign gap     = rmt_r - lct_r;
  assign confirm = exit_r && (!have_r || gap >= {16'b0, cfg.min_gap_ms});
  assign push    = cmd.do_conf && confirm;

  assign head_nxt = !push ? head_r : ((head_r == ppg_pkg::RING_LAST) ? '0 : head_r + 1'b1);

  // Window test of the entry read back
  assign age          = now_r - ring_rdata;
  assign sts.age_over = age > {12'b0, cfg.window_ms};
  assign sts.walk_end = (cnt_r == fill_r);

  ppg_ram #(
    .WIDTH (TW),
    .DEPTH (ppg_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (head_r),
    .wdata (rmt_r),
    .raddr (wp_r),
    .rdata (ring_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      primed_r <= 1'b0;
      inside_r <= 1'b0;
      rmax_r   <= '0;
      rmt_r    <= '0;
      lct_r    <= '0;
      have_r   <= 1'b0;
      exit_r   <= 1'b0;
      head_r   <= '0;
      fill_r   <= '0;
    end else begin
      if (cmd.do_base) begin
        base_r   <= primed_r ? base_nxt : xf;
        primed_r <= 1'b1;
      end
      if (cmd.do_peak) begin
        exit_r <= exit_hit;
        if (enter_hit) begin
          inside_r <= 1'b1;
          rmax_r   <= x_r;
          rmt_r    <= now_r;
        end else if (inside_r && x_r > rmax_r) begin
          rmax_r <= x_r;
          rmt_r  <= now_r;
        end
      end
      if (cmd.do_conf) begin
        head_r <= head_nxt;
        if (exit_r) begin
          inside_r <= 1'b0;
        end
        if (push) begin
          lct_r  <= rmt_r;
          have_r <= 1'b1;
          if (fill_r != ppg_pkg::RING_FULL) begin
            fill_r <= fill_r + 1'b1;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r   <= in_data.ir_sample;
      now_r <= in_data.stamp_ms;
    end
    if (cmd.do_conf) begin
      found_r <= confirm;
      ftime_r <= confirm ? rmt_r : '0;
      // walk starts at the newest entry
      wp_r    <= (head_nxt == '0) ? ppg_pkg::RING_LAST : head_nxt - 1'b1;
      cnt_r   <= '0;
    end
    if (cmd.do_chk) begin
      if (cnt_r == '0) begin
        newest_r <= ring_rdata;
      end
      oldest_r <= ring_rdata;
      cnt_r    <= cnt_r + 1'b1;
      wp_r     <= (wp_r == '0) ? ppg_pkg::RING_LAST : wp_r - 1'b1;
    end
    if (cmd.load_out) begin
      out_r.peak_found     <= found_r;
      out_r.found_time_ms  <= ftime_r;
      out_r.recent_count   <= ppg_pkg::COUNT_W'(cnt_r);
      out_r.recent_span_ms <= (cnt_r >= FW'(2)) ? newest_r - oldest_r : '0;
    end
  end

  assign out_data = out_r;

  // The walk never counts past the stored entries
  a_cnt_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_chk |-> cnt_r < fill_r)
    else $error("window walk beyond ring fill");

  // Fill only moves on a confirmed peak
  a_fill_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != $past(fill_r) |-> $past(push))
    else $error("ring fill changed without a push");

  // A region only closes while one is open
  a_exit_inside: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_conf && exit_r |-> inside_r)
    else $error("region close outside a peak region");

endmodule
